@@ rtl/core/normalized_2d_convolution_assert.svh @@
// Assertion shorthands, clocked on clk and quiet while rst is high.
`ifndef NORMALIZED_2D_CONVOLUTION_ASSERT_SVH
`define NORMALIZED_2D_CONVOLUTION_ASSERT_SVH

// Same-cycle implication.
`define N2C_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("n2c check failed");

// Next-cycle implication.
`define N2C_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("n2c check failed");

`endif

@@ rtl/core/n2c_pkg.sv @@
`default_nettype none

package n2c_pkg;

  // Input beat modes
  localparam logic [1:0] MODE_TAP   = 2'd0;
  localparam logic [1:0] MODE_PIXEL = 2'd1;
  localparam logic [1:0] MODE_FLUSH = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;  // unused, dropped

  // Configuration register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_KERNEL_WIDTH  = 2'd2;
  localparam logic [1:0] REG_KERNEL_HEIGHT = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int MAX_HEIGHT = 2048;
  localparam int HEIGHT_W   = 12;  // holds 0..MAX_HEIGHT
  localparam int ROW_W      = 11;  // holds 0..MAX_HEIGHT-1
  localparam int Q_DEPTH    = 4;

  typedef struct packed {
    logic [1:0] mode;
    logic [5:0] tap_index;
    logic [7:0] chan_r;
    logic [7:0] chan_g;
    logic [7:0] chan_b;
    logic [7:0] chan_a;
  } item_t;

  typedef struct packed {
    logic [7:0] out_r;
    logic [7:0] out_g;
    logic [7:0] out_b;
    logic [7:0] out_a;
    logic       frame_end;
  } result_t;

  typedef enum logic [1:0] {
    OP_TAP,
    OP_PIXEL,
    OP_FLUSH
  } op_t;

  // One classified command; pix is {r, g, b, a}
  typedef struct packed {
    op_t        op;
    logic [5:0] tap;
    logic [31:0] pix;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/n2c_front.sv @@
`default_nettype none

module n2c_front
  import n2c_pkg::*;
#(
  parameter int MAX_KERNEL = 7
) (
  input  wire logic  item_valid,
  output logic       item_ready,
  input  wire item_t item,
  input  wire logic  q_full,
  output logic       push,
  output cmd_t       push_cmd
);

  localparam int TAPS = MAX_KERNEL * MAX_KERNEL;

  // Decode mode; drop out-of-range taps and the unused mode.
  always_comb begin
    item_ready   = !q_full;
    push         = 1'b0;
    push_cmd.op  = OP_FLUSH;
    push_cmd.tap = item.tap_index;
    push_cmd.pix = {item.chan_r, item.chan_g, item.chan_b, item.chan_a};
    if (item_valid && !q_full) begin
      case (item.mode)
        MODE_TAP: begin
          if (int'(item.tap_index) < TAPS) begin
            push        = 1'b1;
            push_cmd.op = OP_TAP;
          end
        end
        MODE_PIXEL: begin
          push        = 1'b1;
          push_cmd.op = OP_PIXEL;
        end
        MODE_FLUSH: begin
          push        = 1'b1;
          push_cmd.op = OP_FLUSH;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/n2c_queue.sv @@
`default_nettype none

module n2c_queue
  import n2c_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output logic      full,
  output logic      head_valid,
  output cmd_t      head
);

  localparam int QA_W = $clog2(Q_DEPTH);
  localparam int QC_W = $clog2(Q_DEPTH + 1);

  cmd_t            slots [Q_DEPTH];
  logic [QA_W-1:0] wp;
  logic [QA_W-1:0] rp;
  logic [QC_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      cnt <= cnt + QC_W'(push) - QC_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= push_cmd;
    end
  end

  assign full       = (cnt == QC_W'(Q_DEPTH));
  assign head_valid = (cnt != '0);
  assign head       = slots[rp];

endmodule

`default_nettype wire

@@ rtl/core/n2c_back.sv @@
`default_nettype none

module n2c_back
  import n2c_pkg::*;
#(
  parameter int MAX_KERNEL = 7,
  parameter int MAX_WIDTH  = 2048
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  head_valid,
  input  wire cmd_t                  head,
  output logic                       pop,
  output logic                       result_valid,
  input  wire logic                  result_ready,
  output result_t                    result
);

  localparam int RING     = MAX_KERNEL + 1;
  localparam int RING_W   = $clog2(RING);
  localparam int RSW      = RING_W + 2;
  localparam int TAPS     = MAX_KERNEL * MAX_KERNEL;
  localparam int TAP_AW   = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int KW       = $clog2(MAX_KERNEL + 1);
  localparam int WW       = $clog2(MAX_WIDTH + 1);
  localparam int CW       = $clog2(MAX_WIDTH);
  localparam int SXW      = CW + 2;
  localparam int SYW      = ROW_W + 2;
  localparam int ROW_DEPTH = RING * MAX_WIDTH;
  localparam int RA_W     = $clog2(ROW_DEPTH);
  localparam int ACC_W    = 16 + $clog2(TAPS);
  localparam int DEN_W    = 8 + $clog2(TAPS);
  localparam int DSH_W    = DEN_W + 7;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_MAC   = 7'b0000100,
    S_DRAIN = 7'b0001000,
    S_PREP  = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  function automatic logic [WW-1:0] clamp_w(logic [CFG_DATA_W-1:0] v);
    if (v == '0) return WW'(1);
    if (int'(v) > MAX_WIDTH) return WW'(MAX_WIDTH);
    return WW'(v);
  endfunction

  function automatic logic [HEIGHT_W-1:0] clamp_h(logic [CFG_DATA_W-1:0] v);
    if (v == '0) return HEIGHT_W'(1);
    if (int'(v) > MAX_HEIGHT) return HEIGHT_W'(MAX_HEIGHT);
    return HEIGHT_W'(v);
  endfunction

  function automatic logic [KW-1:0] clamp_k(logic [2:0] v);
    if (v == '0) return KW'(1);
    if (int'(v) > MAX_KERNEL) return KW'(MAX_KERNEL);
    return KW'(v);
  endfunction

  // Configuration
  logic [WW-1:0]       w;
  logic [HEIGHT_W-1:0] h;
  logic [KW-1:0]       kw;
  logic [KW-1:0]       kh;

  // Position counters
  logic [CW-1:0]       in_col;
  logic [HEIGHT_W-1:0] in_row;
  logic [RING_W-1:0]   in_ring;
  logic [CW-1:0]       ox;
  logic [ROW_W-1:0]    oy;
  logic [RING_W-1:0]   oring;

  state_t              state;
  logic [KW-1:0]       kx;
  logic [KW-1:0]       ky;
  logic [2:0]          div_step;
  logic                s1_valid;
  logic                s1_in_image;
  logic [TAPS-1:0]     tap_vld;

  // Storage and datapath
  logic [31:0]         row_mem [ROW_DEPTH];
  logic [31:0]         tap_mem [TAPS];
  logic [31:0]         row_q;
  logic [31:0]         tap_q;
  logic                tap_ok;
  logic [ACC_W-1:0]    acc  [4];
  logic [DEN_W-1:0]    den  [4];
  logic [ACC_W-1:0]    num  [4];
  logic [DSH_W-1:0]    dsh  [4];
  logic [7:0]          quot [4];

  // Pixel write side
  logic                restart_in;
  logic [CW-1:0]       wr_col;
  logic [HEIGHT_W-1:0] wr_row;
  logic [RING_W-1:0]   wr_ring;
  logic [CW:0]         col_inc;
  logic                row_we;
  logic                tap_we;
  logic [RA_W-1:0]     row_waddr;

  // Readiness check
  logic [KW-1:0]       kx_off;
  logic [KW-1:0]       ky_off;
  logic [CW:0]         nx_sum;
  logic [CW:0]         nx;
  logic [CW:0]         wm1;
  logic [HEIGHT_W-1:0] ny_sum;
  logic [HEIGHT_W-1:0] ny;
  logic                ready_now;

  // Window addressing
  logic signed [SXW-1:0] sx;
  logic signed [SYW-1:0] sy;
  logic                in_image;
  logic [RSW-1:0]      rsum;
  logic [RING_W-1:0]   rd_ring;
  logic [RA_W-1:0]     row_raddr;
  logic [TAP_AW-1:0]   tap_raddr;

  logic                last_col;
  logic                last_row;
  logic                out_load;

  always_comb begin
    pop        = (state == S_IDLE) && head_valid;
    restart_in = (in_row >= h);
    wr_col     = restart_in ? '0 : in_col;
    wr_row     = restart_in ? '0 : in_row;
    wr_ring    = restart_in ? '0 : in_ring;
    col_inc    = {1'b0, wr_col} + 1'b1;
    row_we     = pop && (head.op == OP_PIXEL);
    tap_we     = pop && (head.op == OP_TAP);
    row_waddr  = RA_W'(RA_W'(wr_ring) * RA_W'(MAX_WIDTH) + RA_W'(wr_col));

    kx_off    = kw - KW'(1) - (kw >> 1);
    ky_off    = kh - KW'(1) - (kh >> 1);
    wm1       = (CW + 1)'(w) - 1'b1;
    nx_sum    = {1'b0, ox} + (CW + 1)'(kx_off);
    nx        = (nx_sum > wm1) ? wm1 : nx_sum;
    ny_sum    = HEIGHT_W'(oy) + HEIGHT_W'(ky_off);
    ny        = (ny_sum > h - 1'b1) ? h - 1'b1 : ny_sum;
    ready_now = (ny < in_row) || ((ny == in_row) && (nx < {1'b0, in_col}));

    sx = $signed(SXW'(ox)) + $signed(SXW'(kx)) - $signed(SXW'(kw >> 1));
    sy = $signed(SYW'(oy)) + $signed(SYW'(ky)) - $signed(SYW'(kh >> 1));
    in_image = !sx[SXW-1] && ($unsigned(sx) < SXW'(w)) &&
               !sy[SYW-1] && ($unsigned(sy) < SYW'(h));
    // ring row of sy, kept as (oring + ky - kh/2) mod RING
    rsum = RSW'(oring) + RSW'(RING) + RSW'(ky) - RSW'(kh >> 1);
    if (rsum >= RSW'(2 * RING)) begin
      rd_ring = RING_W'(rsum - RSW'(2 * RING));
    end else if (rsum >= RSW'(RING)) begin
      rd_ring = RING_W'(rsum - RSW'(RING));
    end else begin
      rd_ring = RING_W'(rsum);
    end
    row_raddr = in_image ?
                RA_W'(RA_W'(rd_ring) * RA_W'(MAX_WIDTH) + RA_W'($unsigned(sx))) : '0;
    tap_raddr = TAP_AW'(TAP_AW'(ky) * TAP_AW'(MAX_KERNEL) + TAP_AW'(kx));

    last_col = ({1'b0, ox} == wm1);
    last_row = (HEIGHT_W'(oy) == h - 1'b1);
    out_load = (state == S_OUT) && (!result_valid || result_ready);
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      w            <= WW'(640);
      h            <= HEIGHT_W'(480);
      kw           <= KW'(3);
      kh           <= KW'(3);
      in_col       <= '0;
      in_row       <= '0;
      in_ring      <= '0;
      ox           <= '0;
      oy           <= '0;
      oring        <= '0;
      state        <= S_IDLE;
      kx           <= '0;
      ky           <= '0;
      div_step     <= '0;
      s1_valid     <= 1'b0;
      s1_in_image  <= 1'b0;
      tap_vld      <= '0;
      result_valid <= 1'b0;
    end else begin
      s1_valid    <= (state == S_MAC);
      s1_in_image <= in_image;
      if (result_ready && !out_load) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            case (head.op)
              OP_TAP: begin
                tap_vld[TAP_AW'(head.tap)] <= 1'b1;
              end
              OP_PIXEL: begin
                if (restart_in) begin
                  ox    <= '0;
                  oy    <= '0;
                  oring <= '0;
                end
                if (col_inc >= (CW + 1)'(w)) begin
                  in_col  <= '0;
                  in_row  <= wr_row + 1'b1;
                  in_ring <= (wr_ring == RING_W'(RING - 1)) ? '0 : wr_ring + 1'b1;
                end else begin
                  in_col  <= CW'(col_inc);
                  in_row  <= wr_row;
                  in_ring <= wr_ring;
                end
                state <= S_CHECK;
              end
              OP_FLUSH: begin
                state <= S_CHECK;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_CHECK: begin
          kx    <= '0;
          ky    <= '0;
          state <= ready_now ? S_MAC : S_IDLE;
        end
        S_MAC: begin
          if (kx == kw - 1'b1) begin
            kx <= '0;
            if (ky == kh - 1'b1) begin
              state <= S_DRAIN;
            end else begin
              ky <= ky + 1'b1;
            end
          end else begin
            kx <= kx + 1'b1;
          end
        end
        S_DRAIN: begin
          state <= S_PREP;
        end
        S_PREP: begin
          div_step <= 3'd7;
          state    <= S_DIV;
        end
        S_DIV: begin
          div_step <= div_step - 1'b1;
          if (div_step == '0) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            result_valid <= 1'b1;
            state        <= S_IDLE;
            if (last_col && last_row) begin
              // frame done: everything starts over
              in_col  <= '0;
              in_row  <= '0;
              in_ring <= '0;
              ox      <= '0;
              oy      <= '0;
              oring   <= '0;
            end else if (last_col) begin
              ox    <= '0;
              oy    <= oy + 1'b1;
              oring <= (oring == RING_W'(RING - 1)) ? '0 : oring + 1'b1;
            end else begin
              ox <= ox + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cfg_valid) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:   w  <= clamp_w(cfg_data);
          REG_IMAGE_HEIGHT:  h  <= clamp_h(cfg_data);
          REG_KERNEL_WIDTH:  kw <= clamp_k(cfg_data[2:0]);
          REG_KERNEL_HEIGHT: kh <= clamp_k(cfg_data[2:0]);
          default: ;
        endcase
        in_col  <= '0;
        in_row  <= '0;
        in_ring <= '0;
        ox      <= '0;
        oy      <= '0;
        oring   <= '0;
      end
    end
  end

  // Row ring memory
  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_waddr] <= head.pix;
    end
    row_q <= row_mem[row_raddr];
  end

  // Tap memory; unwritten taps read as zero through tap_vld
  always_ff @(posedge clk) begin
    if (tap_we) begin
      tap_mem[TAP_AW'(head.tap)] <= head.pix;
    end
    tap_q  <= tap_mem[tap_raddr];
    tap_ok <= tap_vld[tap_raddr];
  end

  // Multiply-accumulate and restoring divide, one lane per channel
  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      logic [7:0] f;
      logic [7:0] p;
      f = tap_ok ? tap_q[31 - 8 * c -: 8] : 8'd0;
      p = row_q[31 - 8 * c -: 8];
      case (state)
        S_CHECK: begin
          acc[c] <= '0;
          den[c] <= '0;
        end
        S_PREP: begin
          num[c]  <= acc[c] + ACC_W'(den[c] >> 1);
          dsh[c]  <= {den[c], 7'd0};
          quot[c] <= '0;
        end
        S_DIV: begin
          if (num[c] >= ACC_W'(dsh[c])) begin
            num[c]  <= num[c] - ACC_W'(dsh[c]);
            quot[c] <= {quot[c][6:0], 1'b1};
          end else begin
            quot[c] <= {quot[c][6:0], 1'b0};
          end
          dsh[c] <= dsh[c] >> 1;
        end
        default: ;
      endcase
      if (s1_valid) begin
        acc[c] <= acc[c] + (s1_in_image ? ACC_W'(f * p) : '0);
        den[c] <= den[c] + DEN_W'(f);
      end
    end
    if (out_load) begin
      result.out_r     <= (den[0] == '0) ? 8'd0 : quot[0];
      result.out_g     <= (den[1] == '0) ? 8'd0 : quot[1];
      result.out_b     <= (den[2] == '0) ? 8'd0 : quot[2];
      result.out_a     <= (den[3] == '0) ? 8'd0 : quot[3];
      result.frame_end <= last_col && last_row;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/normalized_2d_convolution.sv @@
// Normalized 2D convolution of an RGBA raster, zero padded.
// item channel: one beat per command. mode 0 loads kernel tap tap_index
// (row*MAX_KERNEL+column), mode 1 brings the next pixel in raster order,
// mode 2 releases one finished result if one is ready. mode 3 is dropped.
// result channel: one beat per output pixel, raster order, frame_end on the
// last pixel of the frame. Each channel is sum(p*f)/sum(f), rounded; a zero
// weight sum gives 0.
// cfg channel: cfg_index 0..3 picks image width, image height, kernel width,
// kernel height; always ready. Any write restarts the frame, taps are kept.
// A front stage decodes beats into a 4-entry command queue; the back engine
// runs one command at a time. A tap load leaves the engine idle; a pixel or
// flush with no result only passes the check state; one with a result
// walks the window one tap per cycle over the single read port of the row
// ring memory and tap memory, then an 8-step divider runs per channel.
// The result sits in an output register; if the receiver stalls the engine
// waits there, and the queue keeps taking beats until it fills.
// Reset: sync, active high. Registers go to 640x480 and a 3x3 kernel, all
// taps read as zero, counters clear. No memory clearing pass is needed.
`default_nettype none

`include "normalized_2d_convolution_assert.svh"

module normalized_2d_convolution
  import n2c_pkg::*;
#(
  parameter int MAX_KERNEL = 7,
  parameter int MAX_WIDTH  = 2048
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  output logic                       item_ready,
  input  wire item_t                 item,
  output logic                       result_valid,
  input  wire logic                  result_ready,
  output result_t                    result,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic q_push;
  cmd_t q_push_cmd;
  logic q_pop;
  logic q_full;
  logic q_head_valid;
  cmd_t q_head;

  // register writes never stall
  assign cfg_ready = 1'b1;

  n2c_front #(
    .MAX_KERNEL (MAX_KERNEL)
  ) u_front (
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_full     (q_full),
    .push       (q_push),
    .push_cmd   (q_push_cmd)
  );

  n2c_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  n2c_back #(
    .MAX_KERNEL (MAX_KERNEL),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .head_valid   (q_head_valid),
    .head         (q_head),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // queue never overflows or underflows
  `N2C_ASSERT_NOW(a_push_room, q_push, !q_full)
  `N2C_ASSERT_NOW(a_pop_data, q_pop, q_head_valid)
  // a pixel or flush occupies the engine for at least the check cycle
  `N2C_ASSERT_NEXT(a_busy_after_pop, q_pop && (q_head.op != OP_TAP), !q_pop)

endmodule

`default_nettype wire

@@ dv/normalized_2d_convolution_checker.sv @@
// Watches the item, config and result channels of the filter, keeps its own
// copy of taps, line ring and frame counters, and checks every result beat.
module normalized_2d_convolution_checker
  import n2c_pkg::*;
#(
  parameter int MAX_KERNEL = 7,
  parameter int MAX_WIDTH  = 2048
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  logic                  item_ready,
  input  item_t                 item,
  input  logic                  result_valid,
  input  logic                  result_ready,
  input  result_t               result,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    awaited
);

  localparam int RING = MAX_KERNEL + 1;
  localparam int TAPS = MAX_KERNEL * MAX_KERNEL;

  logic [31:0] taps [TAPS];
  logic [31:0] lines [RING][MAX_WIDTH];
  int img_w, img_h, ker_w, ker_h;
  int in_col, in_row, emitted;
  result_t filtered_q [$];

  function automatic int clamp(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic bit next_is_ready();
    int ox, oy, nx, ny;
    if (emitted >= img_w * img_h) return 1'b0;
    ox = emitted % img_w;
    oy = emitted / img_w;
    nx = clamp(ox + ker_w - 1 - ker_w / 2, 0, img_w - 1);
    ny = clamp(oy + ker_h - 1 - ker_h / 2, 0, img_h - 1);
    return ny * img_w + nx < in_row * img_w + in_col;
  endfunction

  // Normalized weighted sum at the output cursor; advances the cursor.
  function automatic result_t filter_at_cursor();
    result_t r;
    int ox, oy, sx, sy;
    longint num [4];
    longint den [4];
    logic [7:0] chan [4];
    logic [31:0] f, p;
    ox = emitted % img_w;
    oy = emitted / img_w;
    for (int c = 0; c < 4; c++) begin
      num[c] = 0;
      den[c] = 0;
    end
    for (int ky = 0; ky < ker_h; ky++) begin
      for (int kx = 0; kx < ker_w; kx++) begin
        f  = taps[ky * MAX_KERNEL + kx];
        sx = ox + kx - ker_w / 2;
        sy = oy + ky - ker_h / 2;
        p  = (sx >= 0 && sy >= 0 && sx < img_w && sy < img_h) ? lines[sy % RING][sx] : '0;
        for (int c = 0; c < 4; c++) begin
          // channel 0 is red in the top byte
          den[c] += f[31 - 8 * c -: 8];
          num[c] += f[31 - 8 * c -: 8] * p[31 - 8 * c -: 8];
        end
      end
    end
    for (int c = 0; c < 4; c++)
      chan[c] = den[c] != 0 ? 8'((num[c] + den[c] / 2) / den[c]) : 8'd0;
    r.out_r = chan[0];
    r.out_g = chan[1];
    r.out_b = chan[2];
    r.out_a = chan[3];
    emitted++;
    r.frame_end = emitted == img_w * img_h;
    if (r.frame_end) begin
      in_col  = 0;
      in_row  = 0;
      emitted = 0;
    end
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (taps[i]) taps[i] = '0;
      img_w   = 640;
      img_h   = 480;
      ker_w   = 3;
      ker_h   = 3;
      in_col  = 0;
      in_row  = 0;
      emitted = 0;
      mismatches = 0;
      filtered_q.delete();
    end else begin
      // result beat first: it can never come from an item in this same beat
      if (result_valid && result_ready) begin
        if (filtered_q.size() == 0) begin
          $display("%0t: result beat with none expected, got %h", $time, result);
          mismatches++;
        end else begin
          result_t want;
          want = filtered_q.pop_front();
          check_field("out_r", want.out_r, result.out_r);
          check_field("out_g", want.out_g, result.out_g);
          check_field("out_b", want.out_b, result.out_b);
          check_field("out_a", want.out_a, result.out_a);
          check_field("frame_end", want.frame_end, result.frame_end);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:   img_w = clamp(cfg_data, 1, MAX_WIDTH);
          REG_IMAGE_HEIGHT:  img_h = clamp(cfg_data, 1, MAX_HEIGHT);
          REG_KERNEL_WIDTH:  ker_w = clamp(cfg_data[2:0], 1, MAX_KERNEL);
          REG_KERNEL_HEIGHT: ker_h = clamp(cfg_data[2:0], 1, MAX_KERNEL);
          default: ;
        endcase
        in_col  = 0;
        in_row  = 0;
        emitted = 0;
      end
      if (item_valid && item_ready) begin
        case (item.mode)
          MODE_TAP:
            if (item.tap_index < TAPS)
              taps[item.tap_index] = {item.chan_r, item.chan_g, item.chan_b, item.chan_a};
          MODE_PIXEL: begin
            if (in_row >= img_h) begin
              in_col  = 0;
              in_row  = 0;
              emitted = 0;
            end
            lines[in_row % RING][in_col] = {item.chan_r, item.chan_g, item.chan_b, item.chan_a};
            in_col++;
            if (in_col >= img_w) begin
              in_col = 0;
              in_row++;
            end
            if (next_is_ready()) filtered_q.push_back(filter_at_cursor());
          end
          MODE_FLUSH:
            if (next_is_ready()) filtered_q.push_back(filter_at_cursor());
          default: ;
        endcase
      end
    end
    awaited = filtered_q.size();
  end

endmodule

@@ dv/normalized_2d_convolution_tb.sv @@
// Stimulus and verdict for the normalized 2D convolution filter.
// The checker beside the block predicts and compares; this module only
// makes traffic: config phases, kernel loads, pixel frames, flush beats.
module normalized_2d_convolution_tb;
  import n2c_pkg::*;

  localparam int MAX_KERNEL = 7;
  localparam int MAX_WIDTH  = 2048;
  localparam int DRAIN_CYCLES = 400;  // enough for a full queue of 4 commands at the largest kernel

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_ready;
  item_t                 item = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  result_t               result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches, awaited;
  int random_items;      // items sent during the random part
  int result_beats;
  bit tx_burst, rx_burst;

  normalized_2d_convolution #(.MAX_KERNEL(MAX_KERNEL), .MAX_WIDTH(MAX_WIDTH)) u_top (
    .clk, .rst, .item_valid, .item_ready, .item, .result_valid, .result_ready,
    .result, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  normalized_2d_convolution_checker #(.MAX_KERNEL(MAX_KERNEL), .MAX_WIDTH(MAX_WIDTH)) u_chk (
    .clk, .rst, .item_valid, .item_ready, .item, .result_valid, .result_ready,
    .result, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .mismatches, .awaited
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #(12 * 4_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: random stalls per beat, burst stretches, one long hold-off
  // so the command queue fills and item_ready drops.
  initial begin
    int gap;
    forever begin
      gap = rx_burst ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      result_beats++;
      if (result_beats % 50 == 0) rx_burst = !rx_burst;
      if (result_beats == 30) begin
        result_ready <= 1'b0;
        repeat (600) @(posedge clk);
      end
    end
  end

  function automatic item_t make_beat(logic [1:0] mode, logic [5:0] tap, logic [31:0] pix);
    item_t it;
    it.mode      = mode;
    it.tap_index = tap;
    {it.chan_r, it.chan_g, it.chan_b, it.chan_a} = pix;
    return it;
  endfunction

  // Returns at the edge the beat is taken; valid stays up for a zero gap.
  task automatic send(item_t it);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    random_items++;
  endtask

  // Sender stops until every expected beat is back, then lets the engine
  // finish commands that give no result.
  task automatic wait_idle();
    item_valid <= 1'b0;
    @(posedge clk);
    do @(posedge clk); while (awaited != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(int wv, int hv, int kwv, int khv);
    logic [CFG_IDX_W-1:0] idx [4];
    int vals [4];
    idx  = '{REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_KERNEL_WIDTH, REG_KERNEL_HEIGHT};
    vals = '{wv, hv, kwv, khv};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= CFG_DATA_W'(vals[i]);
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_pix();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Kernel load; a zero-mask channel gets zero weights, so its sum is zero.
  task automatic load_kernel(int kw, int kh);
    logic [3:0] zmask;
    logic [31:0] w;
    zmask = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'h0;
    for (int ky = 0; ky < kh; ky++) begin
      for (int kx = 0; kx < kw; kx++) begin
        w = ($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFF : $urandom;
        for (int c = 0; c < 4; c++)
          if (zmask[c]) w[31 - 8 * c -: 8] = 8'h0;
        send(make_beat(MODE_TAP, 6'(ky * MAX_KERNEL + kx), w));
      end
    end
  endtask

  // One frame of pixels, noise mixed in if small, then (if flush) enough flush
  // beats to release everything still held (plus a couple that find nothing).
  task automatic send_frame(int w, int h, int kw, int kh, int count, bit flush);
    int ahead;
    bit noisy;
    noisy = w * h <= 200;
    for (int i = 0; i < count; i++) begin
      if (noisy) begin
        case ($urandom_range(0, 49))
          0, 1, 2, 3: send(make_beat(MODE_FLUSH, 6'($urandom), $urandom));
          4: send(make_beat(MODE_TAP, 6'($urandom_range(0, 48)), $urandom));
          5: send(make_beat(MODE_TAP, 6'($urandom_range(49, 63)), $urandom));
          6: send(make_beat(MODE_SPARE, 6'($urandom), $urandom));
          default: ;
        endcase
      end
      send(make_beat(MODE_PIXEL, 6'($urandom), rand_pix()));
    end
    if (flush) begin
      ahead = (kh - 1 - kh / 2) * w + (kw - 1 - kw / 2);
      if (ahead > w * h) ahead = w * h;
      repeat (ahead + 2) send(make_beat(MODE_FLUSH, 6'($urandom), $urandom));
    end
  endtask

  function automatic int clip(int v, int hi);
    return v < 1 ? 1 : (v > hi ? hi : v);
  endfunction

  // One config phase from raw register values; large frames are cut short.
  task automatic run_phase(int wv, int hv, int kwv, int khv);
    int w, h, kw, kh;
    w  = clip(wv, MAX_WIDTH);
    h  = clip(hv, MAX_HEIGHT);
    kw = clip(kwv % 8, MAX_KERNEL);
    kh = clip(khv % 8, MAX_KERNEL);
    wait_idle();
    write_regs(wv, hv, kwv, khv);
    tx_burst = $urandom_range(0, 3) == 0;
    load_kernel(kw, kh);
    if (w * h > 200) begin
      send_frame(w, h, kw, kh, $urandom_range(30, 60), 1'b1);
    end else begin
      case ($urandom_range(0, 7))
        0: send_frame(w, h, kw, kh, $urandom_range(1, w * h), 1'b0);  // cut short
        1: begin
          // whole frame left pending, then a new frame starts over it
          send_frame(w, h, kw, kh, w * h, 1'b0);
          send_frame(w, h, kw, kh, w * h, 1'b1);
        end
        default: send_frame(w, h, kw, kh, w * h, 1'b1);
      endcase
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: 3x2 image, 3x3 kernel, alpha weights all zero.
    write_regs(3, 2, 3, 3);
    send(make_beat(MODE_TAP, 6'd0, 32'hFFFF_FF00));
    send(make_beat(MODE_TAP, 6'd8, 32'h0080_0100));
    send(make_beat(MODE_TAP, 6'd16, 32'hFF00_0000));
    send(make_beat(MODE_TAP, 6'd48, 32'h1234_5678));  // outside kernel in use
    send(make_beat(MODE_TAP, 6'd49, 32'hFFFF_FFFF));  // out of range, ignored
    send(make_beat(MODE_TAP, 6'd63, 32'hFFFF_FFFF));
    send(make_beat(MODE_SPARE, 6'd63, 32'hFFFF_FFFF)); // unused mode
    send(make_beat(MODE_PIXEL, 6'd0, 32'h0000_0000));
    send(make_beat(MODE_PIXEL, 6'd0, 32'hFFFF_FFFF));
    send(make_beat(MODE_FLUSH, 6'd0, 32'h0));         // nothing ready yet
    send(make_beat(MODE_PIXEL, 6'd0, 32'hA5A5_A5A5));
    send(make_beat(MODE_PIXEL, 6'd0, 32'h5A5A_5A5A));
    send(make_beat(MODE_PIXEL, 6'd0, 32'hFF00_FF00));
    send(make_beat(MODE_TAP, 6'd1, 32'h4040_4000));   // tap change mid-frame
    send(make_beat(MODE_FLUSH, 6'd0, 32'h0));         // finds nothing ready
    send(make_beat(MODE_PIXEL, 6'd0, 32'h8080_8080));
    repeat (6) send(make_beat(MODE_FLUSH, 6'd0, 32'h0));

    // Random phases, mostly small images.
    random_items = 0;
    while (random_items < 450) begin
      if ($urandom_range(0, 9) == 0)
        run_phase(0, $urandom_range(0, 3), $urandom_range(0, 7), $urandom_range(0, 7));
      else
        run_phase($urandom_range(1, 9), $urandom_range(1, 6), $urandom_range(1, 7),
                  $urandom_range(1, 7));
    end

    // Extremes: full-size kernel, clamped widest line, tall frame, wide line.
    run_phase(5, 4, 7, 7);
    run_phase(4095, 1, 7, 0);
    run_phase(1, 2048, 1, 7);
    run_phase(2048, 1, 1, 1);

    wait_idle();
    if (mismatches == 0 && awaited == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/n2c_pkg.sv
rtl/core/n2c_front.sv
rtl/core/n2c_queue.sv
rtl/core/n2c_back.sv
rtl/core/normalized_2d_convolution.sv
dv/normalized_2d_convolution_checker.sv
dv/normalized_2d_convolution_tb.sv
